@@ hdl/pdqs_pkg.sv @@
// Package for the point deque with search: request and response payload types,
// command and status codes, and the controller state type.
// No dependencies.
`default_nettype none

package pdqs_pkg;

   localparam int COMMAND_WIDTH = 3;
   localparam int COORD_WIDTH   = 8;
   localparam int KIND_WIDTH    = 2;
   localparam int STATUS_WIDTH  = 2;
   localparam int COUNT_WIDTH   = 7;

   localparam logic [COMMAND_WIDTH-1:0] CMD_PUSH   = 3'd0;
   localparam logic [COMMAND_WIDTH-1:0] CMD_POP    = 3'd1;
   localparam logic [COMMAND_WIDTH-1:0] CMD_FIND   = 3'd2;
   localparam logic [COMMAND_WIDTH-1:0] CMD_DELETE = 3'd3;
   localparam logic [COMMAND_WIDTH-1:0] CMD_CLEAR  = 3'd4;

   localparam logic [STATUS_WIDTH-1:0] STAT_OK        = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STAT_EMPTY     = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STAT_FULL      = 2'd2;
   localparam logic [STATUS_WIDTH-1:0] STAT_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic [COMMAND_WIDTH-1:0] command;
      logic [COORD_WIDTH-1:0]   row;
      logic [COORD_WIDTH-1:0]   column;
      logic [KIND_WIDTH-1:0]    kind;
   } req_type;

   typedef struct packed {
      logic [STATUS_WIDTH-1:0] status;
      logic                    found;
      logic [KIND_WIDTH-1:0]   found_kind;
      logic                    freed_valid;
      logic [COORD_WIDTH-1:0]  freed_row;
      logic [COORD_WIDTH-1:0]  freed_column;
      logic [COUNT_WIDTH-1:0]  entry_count;
      logic                    last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POP,
      ST_SCAN,
      ST_SHIFT,
      ST_CLEAR
   } state_type;

endpackage

`default_nettype wire

@@ hdl/point_deque_with_search.sv @@
// Point deque with associative search: a ring of grid points held in one
// synchronous memory, driven by a small read-modify-write sequencer.
// Depends on pdqs_pkg.
//
// Sequencing (request accepted to first result strobe), one memory port each way:
//   push, unknown command, or any refused request: result straight from idle.
//   pop: reads the oldest point, then shows it. find: reads entries from the
//   front until one matches or the stored count is reached. delete: as find,
//   then compaction of the newer points. clear: one result every cycle.
// Throughput: one request at a time; busy stays high until the last result.
// The receiver cannot stall, so results are never held back.
// Reset is synchronous and clears the count, the front index and the
// sequencer; the memory keeps its contents and needs no clearing pass.
`default_nettype none

module point_deque_with_search
   import pdqs_pkg::*;
#(
   parameter int CAPACITY   = 64,
   parameter int COORD_BITS = 8
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_payload,
   output logic         rsp_strobe,
   output rsp_type      rsp_payload
);

   // Stored coordinates never need more bits than the request carries.
   localparam int STORE_BITS = (COORD_BITS < COORD_WIDTH) ? COORD_BITS : COORD_WIDTH;
   localparam int ENTRY_BITS = 2 * STORE_BITS + KIND_WIDTH;
   localparam int IDX_BITS   = $clog2(CAPACITY);
   localparam int DIST_BITS  = IDX_BITS + 1;
   localparam int CNT_BITS   = $clog2(CAPACITY + 1);
   localparam int SUM_BITS   = IDX_BITS + 2;

   localparam logic [CNT_BITS-1:0]  CNT_FULL = CNT_BITS'(CAPACITY);
   localparam logic [IDX_BITS-1:0]  IDX_LAST = IDX_BITS'(CAPACITY - 1);
   localparam logic [SUM_BITS-1:0]  SUM_CAP  = SUM_BITS'(CAPACITY);

   // ----------------------------------------------------------------------
   // Registers
   // ----------------------------------------------------------------------
   state_type                state_ff, state_in;
   logic [IDX_BITS-1:0]      front_ff, front_in;
   logic [CNT_BITS-1:0]      count_ff, count_in;
   logic [IDX_BITS-1:0]      dist_ff, dist_in;
   logic [COMMAND_WIDTH-1:0] cmd_ff, cmd_in;
   logic [STORE_BITS-1:0]    key_row_ff, key_row_in;
   logic [STORE_BITS-1:0]    key_col_ff, key_col_in;
   logic [STORE_BITS-1:0]    freed_row_ff, freed_row_in;
   logic [STORE_BITS-1:0]    freed_col_ff, freed_col_in;
   rsp_type                  rsp_ff, rsp_in;
   logic                     strobe_ff, strobe_in;
   logic [ENTRY_BITS-1:0]    rd_data_ff;

   // Memory port controls.
   logic                     rd_en;
   logic [DIST_BITS-1:0]     rd_dist;
   logic                     wr_en;
   logic [IDX_BITS-1:0]      wr_slot;
   logic [ENTRY_BITS-1:0]    wr_data;
   logic [IDX_BITS-1:0]      rd_slot;

   logic [ENTRY_BITS-1:0]    point_mem [CAPACITY];

   // Fields of the entry that came back from the memory.
   logic [STORE_BITS-1:0]    rd_row, rd_col;
   logic [KIND_WIDTH-1:0]    rd_kind;

   logic                     accept;
   logic                     scan_match;
   logic                     scan_end;
   logic [DIST_BITS-1:0]     count_dist;
   logic [IDX_BITS-1:0]      front_next;

   // Slot of the point a given distance behind the front, with ring wrap.
   function automatic logic [IDX_BITS-1:0] slot_of(input logic [IDX_BITS-1:0]  front,
                                                   input logic [DIST_BITS-1:0] offset);
      logic [SUM_BITS-1:0] sum;
      sum = SUM_BITS'(front) + SUM_BITS'(offset);
      if (sum >= SUM_CAP) begin
         sum = sum - SUM_CAP;
      end
      return sum[IDX_BITS-1:0];
   endfunction

   assign accept     = start && !busy;
   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_payload = rsp_ff;

   assign rd_row  = rd_data_ff[ENTRY_BITS-1 -: STORE_BITS];
   assign rd_col  = rd_data_ff[KIND_WIDTH +: STORE_BITS];
   assign rd_kind = rd_data_ff[KIND_WIDTH-1:0];

   assign count_dist = DIST_BITS'(count_ff);
   assign scan_match = (rd_row == key_row_ff) && (rd_col == key_col_ff);
   assign scan_end   = (DIST_BITS'(dist_ff) + DIST_BITS'(1)) >= count_dist;
   assign front_next = (front_ff == IDX_LAST) ? '0 : front_ff + IDX_BITS'(1);
   assign rd_slot    = slot_of(front_ff, rd_dist);

   // ----------------------------------------------------------------------
   // Next state
   // ----------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_payload.command)
                  CMD_POP:    state_in = (count_ff != '0) ? ST_POP : ST_IDLE;
                  CMD_FIND:   state_in = (count_ff != '0) ? ST_SCAN : ST_IDLE;
                  CMD_DELETE: state_in = (count_ff != '0) ? ST_SCAN : ST_IDLE;
                  CMD_CLEAR:  state_in = (count_ff != '0) ? ST_CLEAR : ST_IDLE;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_POP: begin
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            if (scan_match) begin
               state_in = (cmd_ff == CMD_DELETE && dist_ff != '0) ? ST_SHIFT : ST_IDLE;
            end else if (scan_end) begin
               state_in = ST_IDLE;
            end
         end
         ST_SHIFT: begin
            state_in = (dist_ff == IDX_BITS'(1)) ? ST_IDLE : ST_SHIFT;
         end
         ST_CLEAR: begin
            state_in = (count_ff == CNT_BITS'(1)) ? ST_IDLE : ST_CLEAR;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ----------------------------------------------------------------------
   // Datapath and memory controls
   // ----------------------------------------------------------------------
   always_comb begin
      front_in     = front_ff;
      count_in     = count_ff;
      dist_in      = dist_ff;
      cmd_in       = cmd_ff;
      key_row_in   = key_row_ff;
      key_col_in   = key_col_ff;
      freed_row_in = freed_row_ff;
      freed_col_in = freed_col_ff;
      rsp_in       = '0;
      strobe_in    = 1'b0;
      rd_en        = 1'b0;
      rd_dist      = '0;
      wr_en        = 1'b0;
      wr_slot      = (front_ff == '0) ? IDX_LAST : front_ff - IDX_BITS'(1);
      wr_data      = {req_payload.row[STORE_BITS-1:0], req_payload.column[STORE_BITS-1:0],
                      req_payload.kind};

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in     = req_payload.command;
               key_row_in = req_payload.row[STORE_BITS-1:0];
               key_col_in = req_payload.column[STORE_BITS-1:0];
               dist_in    = '0;
               case (req_payload.command)
                  CMD_PUSH: begin
                     strobe_in   = 1'b1;
                     rsp_in.last = 1'b1;
                     if (count_ff >= CNT_FULL) begin
                        rsp_in.status = STAT_FULL;
                     end else begin
                        // The new point goes into the slot just ahead of the front.
                        wr_en    = 1'b1;
                        front_in = wr_slot;
                        count_in = count_ff + CNT_BITS'(1);
                     end
                  end
                  CMD_POP, CMD_CLEAR: begin
                     if (count_ff != '0) begin
                        rd_en   = 1'b1;
                        rd_dist = count_dist - DIST_BITS'(1);
                     end else begin
                        strobe_in     = 1'b1;
                        rsp_in.last   = 1'b1;
                        rsp_in.status = (req_payload.command == CMD_POP) ? STAT_EMPTY
                                                                         : STAT_OK;
                     end
                  end
                  CMD_FIND, CMD_DELETE: begin
                     if (count_ff != '0) begin
                        rd_en   = 1'b1;
                        rd_dist = '0;
                     end else begin
                        strobe_in     = 1'b1;
                        rsp_in.last   = 1'b1;
                        rsp_in.status = STAT_EMPTY;
                     end
                  end
                  default: begin
                     strobe_in   = 1'b1;
                     rsp_in.last = 1'b1;
                  end
               endcase
            end
         end
         ST_POP: begin
            strobe_in           = 1'b1;
            rsp_in.last         = 1'b1;
            rsp_in.freed_valid  = 1'b1;
            rsp_in.freed_row    = COORD_WIDTH'(rd_row);
            rsp_in.freed_column = COORD_WIDTH'(rd_col);
            count_in            = count_ff - CNT_BITS'(1);
         end
         ST_SCAN: begin
            if (scan_match) begin
               if (cmd_ff == CMD_FIND) begin
                  strobe_in         = 1'b1;
                  rsp_in.last       = 1'b1;
                  rsp_in.found      = 1'b1;
                  rsp_in.found_kind = rd_kind;
               end else if (dist_ff == '0) begin
                  // Match at the front: just step the front back past it.
                  strobe_in           = 1'b1;
                  rsp_in.last         = 1'b1;
                  rsp_in.found        = 1'b1;
                  rsp_in.freed_valid  = 1'b1;
                  rsp_in.freed_row    = COORD_WIDTH'(rd_row);
                  rsp_in.freed_column = COORD_WIDTH'(rd_col);
                  front_in            = front_next;
                  count_in            = count_ff - CNT_BITS'(1);
               end else begin
                  // Keep the freed point and start moving newer points back by one.
                  freed_row_in = rd_row;
                  freed_col_in = rd_col;
                  rd_en        = 1'b1;
                  rd_dist      = DIST_BITS'(dist_ff) - DIST_BITS'(1);
               end
            end else if (scan_end) begin
               strobe_in     = 1'b1;
               rsp_in.last   = 1'b1;
               rsp_in.status = STAT_NOT_FOUND;
            end else begin
               rd_en   = 1'b1;
               rd_dist = DIST_BITS'(dist_ff) + DIST_BITS'(1);
               dist_in = dist_ff + IDX_BITS'(1);
            end
         end
         ST_SHIFT: begin
            // The entry from one place nearer the front lands at dist_ff.
            wr_en   = 1'b1;
            wr_slot = slot_of(front_ff, DIST_BITS'(dist_ff));
            wr_data = rd_data_ff;
            if (dist_ff == IDX_BITS'(1)) begin
               strobe_in           = 1'b1;
               rsp_in.last         = 1'b1;
               rsp_in.found        = 1'b1;
               rsp_in.freed_valid  = 1'b1;
               rsp_in.freed_row    = COORD_WIDTH'(freed_row_ff);
               rsp_in.freed_column = COORD_WIDTH'(freed_col_ff);
               front_in            = front_next;
               count_in            = count_ff - CNT_BITS'(1);
            end else begin
               rd_en   = 1'b1;
               rd_dist = DIST_BITS'(dist_ff) - DIST_BITS'(2);
               dist_in = dist_ff - IDX_BITS'(1);
            end
         end
         ST_CLEAR: begin
            strobe_in           = 1'b1;
            rsp_in.freed_valid  = 1'b1;
            rsp_in.freed_row    = COORD_WIDTH'(rd_row);
            rsp_in.freed_column = COORD_WIDTH'(rd_col);
            rsp_in.last         = (count_ff == CNT_BITS'(1));
            count_in            = count_ff - CNT_BITS'(1);
            if (count_ff != CNT_BITS'(1)) begin
               rd_en   = 1'b1;
               rd_dist = count_dist - DIST_BITS'(2);
            end
         end
         default: begin
            strobe_in = 1'b0;
         end
      endcase

      rsp_in.entry_count = COUNT_WIDTH'(count_in);
   end

   // ----------------------------------------------------------------------
   // Point memory: one write and one registered read per cycle. Compaction
   // reads each slot before it is overwritten, so no forwarding is needed.
   // ----------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (wr_en) begin
         point_mem[wr_slot] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= point_mem[rd_slot];
      end
   end

   // ----------------------------------------------------------------------
   // Control and payload registers
   // ----------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         front_ff  <= '0;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         front_ff  <= front_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      dist_ff      <= dist_in;
      cmd_ff       <= cmd_in;
      key_row_ff   <= key_row_in;
      key_col_ff   <= key_col_in;
      freed_row_ff <= freed_row_in;
      freed_col_ff <= freed_col_in;
      rsp_ff       <= rsp_in;
   end

   // ----------------------------------------------------------------------
   // Assertions
   // ----------------------------------------------------------------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("stored count exceeds capacity");

   a_last_frees_sequencer: assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && rsp_ff.last) |-> (state_ff == ST_IDLE))
      else $error("final result shown while the sequencer is still busy");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (accept && req_payload.command == CMD_PUSH && count_ff < CNT_FULL)
      |=> (count_ff == $past(count_ff) + CNT_BITS'(1)))
      else $error("accepted push did not grow the store");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR && count_ff == CNT_BITS'(1))
      |=> (count_ff == '0 && state_ff == ST_IDLE))
      else $error("clear did not leave the store empty");

   a_scan_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN || state_ff == ST_POP || state_ff == ST_CLEAR) |-> !wr_en)
      else $error("memory written outside push or compaction");

endmodule

`default_nettype wire
